// ===== rtl/core/cfd_pkg.sv =====
// ----------------------------------------------------------------------------
// Complex FIR decimator package
// Shared sizes, register indexes and the control/status bundles that pass
// between the sequencer and the datapath.
// ----------------------------------------------------------------------------
package cfd_pkg;

  // Filter dimensions.
  localparam int MAX_TAPS    = 256;
  localparam int SAMPLE_BITS = 16;
  localparam int COEFF_BITS  = 20;
  localparam int OUT_BITS    = 44;

  // Derived widths.
  localparam int TAP_IDX_W = $clog2(MAX_TAPS);
  localparam int TAP_CNT_W = $clog2(MAX_TAPS + 1);
  localparam int PROD_W    = SAMPLE_BITS + COEFF_BITS;

  // Field and register widths fixed by the interface.
  localparam int DEC_W       = 8;
  localparam int TAP_REG_W   = 9;
  localparam int IDX_FIELD_W = 8;
  localparam int CFG_DATA_W  = 9;
  localparam int CFG_IDX_W   = 1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_DECIMATION = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TAP_COUNT  = 1'd1;

  // Item command codes.
  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_LOAD   = 1'b1;

  // Commands from the sequencer to the datapath.
  typedef struct packed {
    logic accept_sample;
    logic accept_load;
    logic issue;
    logic publish;
  } cfd_cmd_t;

  // Status from the datapath to the sequencer.
  typedef struct packed {
    logic emit;
    logic last_tap;
    logic pipe_busy;
    logic out_free;
  } cfd_status_t;

endpackage

// ===== rtl/core/cfd_in_if.sv =====
// ----------------------------------------------------------------------------
// Input item channel
// Valid/ready channel carrying either a complex sample or a coefficient load.
// ----------------------------------------------------------------------------
interface cfd_in_if;
  logic                                    valid;
  logic                                    ready;
  logic                                    command;
  logic signed [cfd_pkg::SAMPLE_BITS-1:0]  sample_re;
  logic signed [cfd_pkg::SAMPLE_BITS-1:0]  sample_im;
  logic        [cfd_pkg::IDX_FIELD_W-1:0]  coeff_index;
  logic signed [cfd_pkg::COEFF_BITS-1:0]   coeff_value;

  modport source (
    output valid, command, sample_re, sample_im, coeff_index, coeff_value,
    input  ready
  );

  modport sink (
    input  valid, command, sample_re, sample_im, coeff_index, coeff_value,
    output ready
  );
endinterface

// ===== rtl/core/cfd_out_if.sv =====
// ----------------------------------------------------------------------------
// Output item channel
// Valid/ready channel carrying one full-precision complex filter output.
// ----------------------------------------------------------------------------
interface cfd_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [cfd_pkg::OUT_BITS-1:0]  out_re;
  logic signed [cfd_pkg::OUT_BITS-1:0]  out_im;

  modport source (
    output valid, out_re, out_im,
    input  ready
  );

  modport sink (
    input  valid, out_re, out_im,
    output ready
  );
endinterface

// ===== rtl/core/cfd_datapath.sv =====
// ----------------------------------------------------------------------------
// Complex FIR decimator datapath
// Delay line and coefficient memories, stream counters, the shared complex
// multiply-accumulate pipeline and the output register.
// ----------------------------------------------------------------------------
module cfd_datapath (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    cfg_we,
  input  logic        [cfd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic        [cfd_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic signed [cfd_pkg::SAMPLE_BITS-1:0]  sample_re,
  input  logic signed [cfd_pkg::SAMPLE_BITS-1:0]  sample_im,
  input  logic        [cfd_pkg::IDX_FIELD_W-1:0]  coeff_index,
  input  logic signed [cfd_pkg::COEFF_BITS-1:0]   coeff_value,
  input  cfd_pkg::cfd_cmd_t                       cmd,
  output cfd_pkg::cfd_status_t                    sts,
  input  logic                                    out_ready,
  output logic                                    out_valid,
  output logic signed [cfd_pkg::OUT_BITS-1:0]     out_re,
  output logic signed [cfd_pkg::OUT_BITS-1:0]     out_im
);

  localparam int IW = cfd_pkg::TAP_IDX_W;
  localparam int CW = cfd_pkg::TAP_CNT_W;
  localparam int SB = cfd_pkg::SAMPLE_BITS;

  // Configuration registers.
  logic [cfd_pkg::DEC_W-1:0]     dec_factor;
  logic [cfd_pkg::TAP_REG_W-1:0] tap_count;

  // Stream state.
  logic [IW-1:0]             write_pointer;
  logic [CW-1:0]             fill_count;
  logic [cfd_pkg::DEC_W-1:0] decimation_phase;

  // Memories.
  logic [2*SB-1:0]                      delay_mem [cfd_pkg::MAX_TAPS];
  logic signed [cfd_pkg::COEFF_BITS-1:0] coeff_mem [cfd_pkg::MAX_TAPS];

  // MAC walk state.
  logic [IW-1:0] rd_ptr;
  logic [IW-1:0] tap_idx;
  logic          rd_v;
  logic          mul_v;
  logic [2*SB-1:0]                       d_q;
  logic signed [cfd_pkg::COEFF_BITS-1:0] c_q;
  logic signed [cfd_pkg::PROD_W-1:0]     prod_re;
  logic signed [cfd_pkg::PROD_W-1:0]     prod_im;
  logic signed [cfd_pkg::OUT_BITS-1:0]   acc_re;
  logic signed [cfd_pkg::OUT_BITS-1:0]   acc_im;

  // Effective settings and next-pointer arithmetic.
  logic [CW-1:0]             taps_use;
  logic [cfd_pkg::DEC_W-1:0] dec_use;
  logic [IW-1:0]             wp_eff;
  logic [CW:0]               wp_inc;
  logic [cfd_pkg::DEC_W:0]   phase_inc;
  logic signed [SB-1:0]      d_re;
  logic signed [SB-1:0]      d_im;

  always_comb begin
    if (tap_count == '0) begin
      taps_use = CW'(1);
    end else if (32'(tap_count) > cfd_pkg::MAX_TAPS) begin
      taps_use = CW'(cfd_pkg::MAX_TAPS);
    end else begin
      taps_use = CW'(tap_count);
    end
    dec_use   = (dec_factor == '0) ? cfd_pkg::DEC_W'(1) : dec_factor;
    wp_eff    = (CW'(write_pointer) >= taps_use) ? '0 : write_pointer;
    wp_inc    = (CW+1)'(wp_eff) + (CW+1)'(1);
    phase_inc = {1'b0, decimation_phase} + (cfd_pkg::DEC_W+1)'(1);
    d_re      = d_q[2*SB-1:SB];
    d_im      = d_q[SB-1:0];
  end

  // Status to the sequencer.
  always_comb begin
    sts.emit      = ((CW+1)'(fill_count) + (CW+1)'(1) >= (CW+1)'(taps_use)) &&
                    (decimation_phase == '0);
    sts.last_tap  = ((CW+1)'(tap_idx) + (CW+1)'(1) == (CW+1)'(taps_use));
    sts.pipe_busy = rd_v || mul_v;
    sts.out_free  = !out_valid || out_ready;
  end

  // Configuration and stream counters; a register write restarts the stream.
  always_ff @(posedge clk) begin
    if (rst) begin
      dec_factor        <= cfd_pkg::DEC_W'(1);
      tap_count         <= cfd_pkg::TAP_REG_W'(255);
      write_pointer     <= '0;
      fill_count        <= '0;
      decimation_phase  <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        cfd_pkg::REG_DECIMATION: begin
          dec_factor        <= cfg_data[cfd_pkg::DEC_W-1:0];
          write_pointer     <= '0;
          fill_count        <= '0;
          decimation_phase  <= '0;
        end
        cfd_pkg::REG_TAP_COUNT: begin
          tap_count        <= cfg_data[cfd_pkg::TAP_REG_W-1:0];
          write_pointer    <= '0;
          fill_count       <= '0;
          decimation_phase <= '0;
        end
        default: begin
        end
      endcase
    end else if (cmd.accept_sample) begin
      write_pointer    <= (wp_inc >= (CW+1)'(taps_use)) ? '0 : IW'(wp_inc);
      fill_count       <= (fill_count < taps_use) ? fill_count + CW'(1) : fill_count;
      decimation_phase <= (phase_inc >= (cfd_pkg::DEC_W+1)'(dec_use)) ?
                          '0 : phase_inc[cfd_pkg::DEC_W-1:0];
    end
  end

  // Memory writes: samples into the delay line, loads into the coefficients.
  always_ff @(posedge clk) begin
    if (cmd.accept_sample) begin
      delay_mem[wp_eff] <= {sample_re, sample_im};
    end
    if (cmd.accept_load && (32'(coeff_index) < cfd_pkg::MAX_TAPS)) begin
      coeff_mem[IW'(coeff_index)] <= coeff_value;
    end
  end

  // Tap walk: newest sample first, coefficient index counting up.
  always_ff @(posedge clk) begin
    if (cmd.accept_sample) begin
      rd_ptr  <= wp_eff;
      tap_idx <= '0;
    end else if (cmd.issue) begin
      rd_ptr  <= (rd_ptr == '0) ? IW'(taps_use - CW'(1)) : rd_ptr - IW'(1);
      tap_idx <= tap_idx + IW'(1);
    end
  end

  // Registered memory reads for the tap being issued.
  always_ff @(posedge clk) begin
    if (cmd.issue) begin
      d_q <= delay_mem[rd_ptr];
      c_q <= coeff_mem[tap_idx];
    end
  end

  // Product stage.
  always_ff @(posedge clk) begin
    prod_re <= d_re * c_q;
    prod_im <= d_im * c_q;
  end

  // Pipeline valid bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_v  <= 1'b0;
      mul_v <= 1'b0;
    end else begin
      rd_v  <= cmd.issue;
      mul_v <= rd_v;
    end
  end

  // Accumulator, cleared whenever a sample is accepted.
  always_ff @(posedge clk) begin
    if (cmd.accept_sample) begin
      acc_re <= '0;
      acc_im <= '0;
    end else if (mul_v) begin
      acc_re <= acc_re + cfd_pkg::OUT_BITS'(prod_re);
      acc_im <= acc_im + cfd_pkg::OUT_BITS'(prod_im);
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.publish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.publish) begin
      out_re <= acc_re;
      out_im <= acc_im;
    end
  end

  // The write pointer always stays inside the active delay line.
  assert property (@(posedge clk) disable iff (rst)
    CW'(write_pointer) < taps_use)
    else $error("write pointer outside active taps");

  // The fill count never passes the tap count.
  assert property (@(posedge clk) disable iff (rst)
    fill_count <= taps_use)
    else $error("fill count above tap count");

  // A result is published only after the MAC pipeline has drained.
  assert property (@(posedge clk) disable iff (rst)
    cmd.publish |-> !rd_v && !mul_v)
    else $error("publish while MAC pipeline busy");

endmodule

// ===== rtl/core/cfd_ctrl.sv =====
// ----------------------------------------------------------------------------
// Complex FIR decimator sequencer
// Takes items, starts a tap walk for each sample that yields an output,
// waits for the MAC pipeline to drain and hands the sum to the output stage.
// ----------------------------------------------------------------------------
module cfd_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic                 in_command,
  output logic                 in_ready,
  input  cfd_pkg::cfd_status_t sts,
  output cfd_pkg::cfd_cmd_t    cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_DRAIN,
    S_OUT
  } state_t;

  state_t state;
  state_t state_next;
  logic   accept;

  // Handshake and commands.
  always_comb begin
    in_ready          = (state == S_IDLE);
    accept            = in_valid && in_ready;
    cmd.accept_sample = accept && (in_command == cfd_pkg::CMD_SAMPLE);
    cmd.accept_load   = accept && (in_command == cfd_pkg::CMD_LOAD);
    cmd.issue         = (state == S_RUN);
    cmd.publish       = (state == S_OUT) && sts.out_free;
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (cmd.accept_sample && sts.emit) state_next = S_RUN;
      end
      S_RUN: begin
        if (sts.last_tap) state_next = S_DRAIN;
      end
      S_DRAIN: begin
        if (!sts.pipe_busy) state_next = S_OUT;
      end
      S_OUT: begin
        if (sts.out_free) state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // No new item is taken while a tap walk is in flight.
  assert property (@(posedge clk) disable iff (rst)
    (state == S_RUN || state == S_DRAIN) |-> !in_ready)
    else $error("item accepted during tap walk");

endmodule

// ===== rtl/core/complex_fir_decimator.sv =====
// An emitting sample's result passes the tap walk, the read and product
// registers and the accumulator to the output register; load items and
// samples that emit nothing start no walk. One shared complex MAC walks one
// tap per cycle; new items wait until the sum is published and the output is free.
// Reset (rst, synchronous, active high) sets decimation 1 and 255 taps and
// clears the stream counters; memories hold their contents.
// ----------------------------------------------------------------------------
// Complex FIR decimator
// Complex-sample FIR filter with real coefficients and decimation, built as
// a sequencer around a single shared complex multiply-accumulate datapath.
// ----------------------------------------------------------------------------
module complex_fir_decimator (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [cfd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [cfd_pkg::CFG_DATA_W-1:0]   cfg_data,
  cfd_in_if.sink                           items,
  cfd_out_if.source                        results
);

  cfd_pkg::cfd_cmd_t    cmd;
  cfd_pkg::cfd_status_t sts;

  // Sequencer.
  cfd_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (items.valid),
    .in_command (items.command),
    .in_ready   (items.ready),
    .sts        (sts),
    .cmd        (cmd)
  );

  // Datapath.
  cfd_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .sample_re   (items.sample_re),
    .sample_im   (items.sample_im),
    .coeff_index (items.coeff_index),
    .coeff_value (items.coeff_value),
    .cmd         (cmd),
    .sts         (sts),
    .out_ready   (results.ready),
    .out_valid   (results.valid),
    .out_re      (results.out_re),
    .out_im      (results.out_im)
  );

endmodule
